[rtl/agwu_pkg.sv]
package agwu_pkg;

    // Depth of the squared-gradient store unless the top level overrides it.
    localparam int NUM_WEIGHTS_DEF = 4096;

    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int TDATA_W = 48;

    // Register numbers as seen on paddr[3:2].
    localparam logic [1:0] REG_RATE    = 2'd0;
    localparam logic [1:0] REG_EPSILON = 2'd1;
    localparam logic [1:0] REG_BATCH   = 2'd2;

    localparam logic [30:0] LR_RESET    = 31'd66;
    localparam logic [30:0] EPS_RESET   = 31'd1;
    localparam logic [15:0] BATCH_RESET = 16'd1;

    localparam logic [30:0] STORE_MAX = 31'h7FFF_FFFF;

    localparam int DIV1_STAGES = 32;
    localparam int SQRT_STAGES = 24;
    localparam int DIV2_STAGES = 32;

    // What rides along with an item through every stage.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              neg;
        logic [DATA_W-1:0] gmag;
        logic              inr;
    } item_side_t;

endpackage

[rtl/adagrad_weight_update.sv]
// Channel  | Dir | Handshake                    | Beat contents
// s_       | in  | s_tvalid / s_tready          | weight_index, gradient
// m_       | out | m_tvalid / m_tready          | out_index, delta
// APB      | in  | psel, penable, pwrite, pready| rate, epsilon, batch
//
// One beat enters per cycle and one result leaves per cycle once the pipeline is full,
// while the output is not stalled. Between acceptance and a valid result lie an input
// register, a 32-stage divider for g/batch, two registers around the store
// read-modify-write, a 24-stage square root, three registers for the denominator,
// a 32-stage divider for the delta and the output register.
// After reset a clearing pass writes zero to every store entry, one per cycle;
// s_tready stays low meanwhile.
// The whole pipeline holds when a result is waiting and m_tready is low.
module adagrad_weight_update import agwu_pkg::*; #(
    parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [11:0] weight_index, [43:12] gradient, zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [11:0] out_index, [43:12] delta, zero pad
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    // Configuration registers.
    logic [30:0] lr_reg;
    logic [30:0] eps_reg;
    logic [15:0] batch_reg;
    logic [15:0] b_eff;

    assign pready = 1'b1;
    assign b_eff  = (batch_reg == 16'd0) ? 16'd1 : batch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg    <= LR_RESET;
            eps_reg   <= EPS_RESET;
            batch_reg <= BATCH_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_RATE:    lr_reg    <= pwdata[30:0];
                REG_EPSILON: eps_reg   <= pwdata[30:0];
                REG_BATCH:   batch_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RATE:    prdata = {1'b0, lr_reg};
            REG_EPSILON: prdata = {1'b0, eps_reg};
            REG_BATCH:   prdata = {16'd0, batch_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // The whole pipeline moves together; it only holds when the output is full and stalled.
    logic m_tvalid_reg;
    logic adv;
    logic clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && !clr_busy_reg;

    // Input stage.
    logic        p0_vld_reg;
    item_side_t  p0_side_reg;
    item_side_t  in_side;
    logic [31:0] in_g;

    always_comb begin
        in_g          = s_tdata[43:12];
        in_side.idx   = s_tdata[11:0];
        in_side.neg   = in_g[31];
        in_side.gmag  = in_g[31] ? (~in_g + 32'd1) : in_g;
        in_side.inr   = (32'(s_tdata[11:0]) < 32'(NUM_WEIGHTS));
    end

    // Divider for |g| / batch, one quotient bit per stage.
    logic        d1_vld_reg  [DIV1_STAGES];
    item_side_t  d1_side_reg [DIV1_STAGES];
    logic [15:0] d1_rem_reg  [DIV1_STAGES];
    logic [31:0] d1_quo_reg  [DIV1_STAGES];
    logic [31:0] d1_num_reg  [DIV1_STAGES];
    logic [15:0] d1_rem_next [DIV1_STAGES];
    logic [31:0] d1_quo_next [DIV1_STAGES];
    logic [31:0] d1_num_next [DIV1_STAGES];

    always_comb begin
        logic [15:0] rin;
        logic [31:0] qin;
        logic [31:0] nin;
        logic [16:0] trial;
        logic        ge;
        for (int k = 0; k < DIV1_STAGES; k++) begin
            if (k == 0) begin
                rin = 16'd0;
                qin = 32'd0;
                nin = p0_side_reg.gmag;
            end else begin
                rin = d1_rem_reg[k-1];
                qin = d1_quo_reg[k-1];
                nin = d1_num_reg[k-1];
            end
            trial          = {rin, nin[31]};
            ge             = (trial >= {1'b0, b_eff});
            d1_rem_next[k] = ge ? 16'(trial - {1'b0, b_eff}) : trial[15:0];
            d1_quo_next[k] = {qin[30:0], ge};
            d1_num_next[k] = {nin[30:0], 1'b0};
        end
    end

    // Square, store read and read-modify-write. A quotient of 2^31 squares to 2^62,
    // so the shifted square needs 47 bits.
    logic [30:0] store_mem [NUM_WEIGHTS];
    logic [30:0] mem_rd_reg;
    logic        sq_vld_reg;
    item_side_t  sq_side_reg;
    logic [46:0] sq_reg;
    logic [63:0] sq_prod;
    logic        lw_vld_reg;
    logic [11:0] lw_idx_reg;
    logic [30:0] lw_data_reg;
    logic [30:0] cur_val;
    logic [47:0] sum_wide;
    logic [30:0] s_val;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign sq_prod  = d1_quo_reg[DIV1_STAGES-1] * d1_quo_reg[DIV1_STAGES-1];
    assign rd_addr  = AW'(32'(d1_side_reg[DIV1_STAGES-1].idx));
    assign wr_addr  = AW'(32'(sq_side_reg.idx));

    always_comb begin
        // A write from the item just ahead lands at the same edge as this item's read.
        if (!sq_side_reg.inr) begin
            cur_val = 31'd0;
        end else if (lw_vld_reg && (lw_idx_reg == sq_side_reg.idx)) begin
            cur_val = lw_data_reg;
        end else begin
            cur_val = mem_rd_reg;
        end
        sum_wide = {17'd0, cur_val} + {1'b0, sq_reg};
        s_val    = (sum_wide > 48'(STORE_MAX)) ? STORE_MAX : sum_wide[30:0];
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            store_mem[clr_cnt_reg] <= 31'd0;
        end else if (adv && sq_vld_reg && sq_side_reg.inr) begin
            store_mem[wr_addr] <= s_val;
        end
        if (adv) begin
            mem_rd_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == AW'(NUM_WEIGHTS - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // Square root of S in Q16.16, two radicand bits per stage.
    logic        st_vld_reg;
    item_side_t  st_side_reg;
    logic [30:0] st_s_reg;

    logic        rt_vld_reg  [SQRT_STAGES];
    item_side_t  rt_side_reg [SQRT_STAGES];
    logic [25:0] rt_rem_reg  [SQRT_STAGES];
    logic [23:0] rt_root_reg [SQRT_STAGES];
    logic [47:0] rt_val_reg  [SQRT_STAGES];
    logic [25:0] rt_rem_next  [SQRT_STAGES];
    logic [23:0] rt_root_next [SQRT_STAGES];
    logic [47:0] rt_val_next  [SQRT_STAGES];

    always_comb begin
        logic [25:0] rin;
        logic [23:0] oin;
        logic [47:0] vin;
        logic [27:0] cur;
        logic [27:0] trial;
        logic        ge;
        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (j == 0) begin
                rin = 26'd0;
                oin = 24'd0;
                vin = {1'b0, st_s_reg, 16'd0};
            end else begin
                rin = rt_rem_reg[j-1];
                oin = rt_root_reg[j-1];
                vin = rt_val_reg[j-1];
            end
            cur             = {rin, vin[47:46]};
            trial           = {2'b00, oin, 2'b01};
            ge              = (cur >= trial);
            rt_rem_next[j]  = ge ? 26'(cur - trial) : cur[25:0];
            rt_root_next[j] = {oin[22:0], ge};
            rt_val_next[j]  = {vin[45:0], 2'b00};
        end
    end

    // Denominator and numerator.
    logic        dn_vld_reg;
    item_side_t  dn_side_reg;
    logic [31:0] dn_den_reg;
    logic [62:0] dn_num_reg;

    logic        dd_vld_reg;
    item_side_t  dd_side_reg;
    logic [47:0] dd_d_reg;
    logic [62:0] dd_num_reg;
    logic        dd_zero_reg;

    logic        ov_vld_reg;
    item_side_t  ov_side_reg;
    logic [47:0] ov_d_reg;
    logic [47:0] ov_rem_reg;
    logic [31:0] ov_lo_reg;
    logic        ov_ovf_reg;
    logic        ov_zero_reg;

    // Divider for lr*|g| / (batch*den), 32 quotient bits; larger quotients saturate anyway.
    logic        q2_vld_reg  [DIV2_STAGES];
    item_side_t  q2_side_reg [DIV2_STAGES];
    logic [47:0] q2_d_reg    [DIV2_STAGES];
    logic [47:0] q2_rem_reg  [DIV2_STAGES];
    logic [31:0] q2_quo_reg  [DIV2_STAGES];
    logic [31:0] q2_lo_reg   [DIV2_STAGES];
    logic        q2_ovf_reg  [DIV2_STAGES];
    logic        q2_zero_reg [DIV2_STAGES];
    logic [47:0] q2_rem_next [DIV2_STAGES];
    logic [31:0] q2_quo_next [DIV2_STAGES];
    logic [31:0] q2_lo_next  [DIV2_STAGES];

    always_comb begin
        logic [47:0] rin;
        logic [31:0] qin;
        logic [31:0] lin;
        logic [47:0] din;
        logic [48:0] cur;
        logic        ge;
        for (int k = 0; k < DIV2_STAGES; k++) begin
            if (k == 0) begin
                rin = ov_rem_reg;
                qin = 32'd0;
                lin = ov_lo_reg;
                din = ov_d_reg;
            end else begin
                rin = q2_rem_reg[k-1];
                qin = q2_quo_reg[k-1];
                lin = q2_lo_reg[k-1];
                din = q2_d_reg[k-1];
            end
            cur            = {rin, lin[31]};
            ge             = (cur >= {1'b0, din});
            q2_rem_next[k] = ge ? 48'(cur - {1'b0, din}) : cur[47:0];
            q2_quo_next[k] = {qin[30:0], ge};
            q2_lo_next[k]  = {lin[30:0], 1'b0};
        end
    end

    // Sign, saturation and output register.
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [31:0]        delta;
    logic [31:0]        q_fin;
    logic [31:0]        mag;
    item_side_t         fin_side;

    always_comb begin
        fin_side = q2_side_reg[DIV2_STAGES-1];
        q_fin    = q2_quo_reg[DIV2_STAGES-1];
        if (q2_zero_reg[DIV2_STAGES-1]) begin
            mag   = 32'd0;
            delta = 32'd0;
        end else if (fin_side.neg) begin
            mag   = (q2_ovf_reg[DIV2_STAGES-1] || q_fin > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                          : q_fin;
            delta = mag;
        end else begin
            mag   = (q2_ovf_reg[DIV2_STAGES-1] || q_fin > 32'h8000_0000) ? 32'h8000_0000
                                                                          : q_fin;
            delta = ~mag + 32'd1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg   <= 1'b0;
            sq_vld_reg   <= 1'b0;
            st_vld_reg   <= 1'b0;
            dn_vld_reg   <= 1'b0;
            dd_vld_reg   <= 1'b0;
            ov_vld_reg   <= 1'b0;
            lw_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < DIV1_STAGES; k++) d1_vld_reg[k] <= 1'b0;
            for (int j = 0; j < SQRT_STAGES; j++) rt_vld_reg[j] <= 1'b0;
            for (int k = 0; k < DIV2_STAGES; k++) q2_vld_reg[k] <= 1'b0;
        end else if (adv) begin
            p0_vld_reg <= s_tvalid && s_tready;
            d1_vld_reg[0] <= p0_vld_reg;
            for (int k = 1; k < DIV1_STAGES; k++) d1_vld_reg[k] <= d1_vld_reg[k-1];
            sq_vld_reg <= d1_vld_reg[DIV1_STAGES-1];
            lw_vld_reg <= sq_vld_reg && sq_side_reg.inr;
            st_vld_reg <= sq_vld_reg;
            rt_vld_reg[0] <= st_vld_reg;
            for (int j = 1; j < SQRT_STAGES; j++) rt_vld_reg[j] <= rt_vld_reg[j-1];
            dn_vld_reg <= rt_vld_reg[SQRT_STAGES-1];
            dd_vld_reg <= dn_vld_reg;
            ov_vld_reg <= dd_vld_reg;
            q2_vld_reg[0] <= ov_vld_reg;
            for (int k = 1; k < DIV2_STAGES; k++) q2_vld_reg[k] <= q2_vld_reg[k-1];
            m_tvalid_reg <= q2_vld_reg[DIV2_STAGES-1];
        end
    end

    // Payload of every stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_side_reg <= in_side;

            d1_side_reg[0] <= p0_side_reg;
            for (int k = 1; k < DIV1_STAGES; k++) d1_side_reg[k] <= d1_side_reg[k-1];
            for (int k = 0; k < DIV1_STAGES; k++) begin
                d1_rem_reg[k] <= d1_rem_next[k];
                d1_quo_reg[k] <= d1_quo_next[k];
                d1_num_reg[k] <= d1_num_next[k];
            end

            sq_side_reg <= d1_side_reg[DIV1_STAGES-1];
            sq_reg      <= sq_prod[62:16];

            lw_idx_reg  <= sq_side_reg.idx;
            lw_data_reg <= s_val;

            st_side_reg <= sq_side_reg;
            st_s_reg    <= s_val;

            rt_side_reg[0] <= st_side_reg;
            for (int j = 1; j < SQRT_STAGES; j++) rt_side_reg[j] <= rt_side_reg[j-1];
            for (int j = 0; j < SQRT_STAGES; j++) begin
                rt_rem_reg[j]  <= rt_rem_next[j];
                rt_root_reg[j] <= rt_root_next[j];
                rt_val_reg[j]  <= rt_val_next[j];
            end

            dn_side_reg <= rt_side_reg[SQRT_STAGES-1];
            dn_den_reg  <= {8'd0, rt_root_reg[SQRT_STAGES-1]} + {1'b0, eps_reg};
            dn_num_reg  <= lr_reg * rt_side_reg[SQRT_STAGES-1].gmag;

            dd_side_reg <= dn_side_reg;
            dd_d_reg    <= b_eff * dn_den_reg;
            dd_num_reg  <= dn_num_reg;
            dd_zero_reg <= (dn_side_reg.gmag == 32'd0) || (dn_den_reg == 32'd0);

            ov_side_reg <= dd_side_reg;
            ov_d_reg    <= dd_d_reg;
            ov_rem_reg  <= {17'd0, dd_num_reg[62:32]};
            ov_lo_reg   <= dd_num_reg[31:0];
            ov_ovf_reg  <= ({17'd0, dd_num_reg[62:32]} >= dd_d_reg);
            ov_zero_reg <= dd_zero_reg;

            q2_side_reg[0] <= ov_side_reg;
            q2_d_reg[0]    <= ov_d_reg;
            q2_ovf_reg[0]  <= ov_ovf_reg;
            q2_zero_reg[0] <= ov_zero_reg;
            for (int k = 1; k < DIV2_STAGES; k++) begin
                q2_side_reg[k] <= q2_side_reg[k-1];
                q2_d_reg[k]    <= q2_d_reg[k-1];
                q2_ovf_reg[k]  <= q2_ovf_reg[k-1];
                q2_zero_reg[k] <= q2_zero_reg[k-1];
            end
            for (int k = 0; k < DIV2_STAGES; k++) begin
                q2_rem_reg[k] <= q2_rem_next[k];
                q2_quo_reg[k] <= q2_quo_next[k];
                q2_lo_reg[k]  <= q2_lo_next[k];
            end

            m_tdata_reg <= {4'd0, delta, fin_side.idx};
        end
    end

endmodule

[sim/tb_adagrad_weight_update.sv]
`timescale 1ns / 1ps

module tb_adagrad_weight_update;
    import agwu_pkg::*;

    localparam int NW         = NUM_WEIGHTS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYC  = 200;
    localparam int HOLD_CYC   = 400;

    // Packed with the index in the low bits, as on the bus.
    typedef struct packed {
        logic [DATA_W-1:0] grad;
        logic [IDX_W-1:0]  idx;
    } grad_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] delta;
        logic [IDX_W-1:0]  idx;
    } delta_beat_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    adagrad_weight_update dut (.*);

    // Predictor state: a private copy of the store and the three registers.
    logic [31:0] sq_store [NW];
    logic [30:0] lr_reg;
    logic [30:0] eps_reg;
    logic [15:0] batch_reg;

    grad_beat_t  grad_queue[$];   // beats waiting to be driven
    delta_beat_t delta_queue[$];  // deltas predicted but not yet seen
    int          err_count;
    int          sent_count;
    int          idle_cycles;
    bit          quiet_phase;     // no idling on either side near the end
    bit          hold_req;        // asks the sink to hold off for a long stretch
    bit          in_taken;        // the input beat was accepted at the last rising edge

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Integer square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Works out the AdaGrad delta for one gradient beat and updates the store copy.
    function automatic delta_beat_t adagrad_delta(input grad_beat_t b);
        delta_beat_t r;
        logic        neg;
        logic [63:0] gmag, bsz, qmag, sq, sum, den, mag;
        neg  = b.grad[31];
        gmag = neg ? {32'd0, (~b.grad) + 32'd1} : {32'd0, b.grad};
        bsz  = (batch_reg == 0) ? 64'd1 : {48'd0, batch_reg};
        qmag = gmag / bsz;
        sq   = (qmag * qmag) >> 16;
        sum  = ((b.idx < NW) ? {32'd0, sq_store[b.idx]} : 64'd0) + sq;
        if (sum > 64'h7FFF_FFFF) sum = 64'h7FFF_FFFF;
        if (b.idx < NW) sq_store[b.idx] = sum[31:0];
        den = isqrt(sum << 16) + {33'd0, eps_reg};
        r.idx = b.idx;
        if (gmag == 0 || den == 0) begin
            r.delta = 32'd0;
        end else begin
            mag = ({33'd0, lr_reg} * gmag) / (bsz * den);
            if (neg) begin
                if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                r.delta = mag[31:0];
            end else begin
                if (mag > 64'h8000_0000) mag = 64'h8000_0000;
                r.delta = (~mag[31:0]) + 32'd1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // APB write: setup then access, applied to the predictor at the same edge.
    task automatic reg_write(input logic [1:0] regnum, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regnum, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (regnum)
            REG_RATE:    lr_reg    = val[30:0];
            REG_EPSILON: eps_reg   = val[30:0];
            default:     batch_reg = val[15:0];
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] lr, input logic [31:0] eps,
                            input logic [31:0] bsz);
        reg_write(REG_RATE, lr);
        reg_write(REG_EPSILON, eps);
        reg_write(REG_BATCH, bsz);
    endtask

    task automatic push_beat(input logic [IDX_W-1:0] idx, input logic [31:0] g);
        grad_beat_t b;
        b.idx  = idx;
        b.grad = g;
        grad_queue.push_back(b);
    endtask

    // Waits until every queued beat has been sent and every delta has come back,
    // then lets the pipeline drain before registers may change.
    task automatic wait_idle();
        while (grad_queue.size() != 0 || s_tvalid || delta_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // A random gradient: mostly modest magnitudes, sometimes the full range.
    function automatic logic [31:0] rand_grad();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h8000_0000 | $urandom_range(0, 3);
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3:       return $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                 : -$urandom_range(0, 255);
            default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000)
                                                 : -$urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // Driver: presents the head of the pending queue, with random bursts of idling.
    int src_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (s_tvalid && !in_taken) begin
            // Hold the beat until it is taken.
        end else if (src_gap > 0) begin
            s_tvalid <= 1'b0;
            src_gap  <= src_gap - 1;
        end else if (grad_queue.size() != 0) begin
            s_tdata  <= {{(TDATA_W-IDX_W-DATA_W){1'b0}}, grad_queue[0].grad,
                         grad_queue[0].idx};
            s_tvalid <= 1'b1;
            void'(grad_queue.pop_front());
            if (!quiet_phase && $urandom_range(0, 9) == 0)
                src_gap <= $urandom_range(1, 5);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Sink: random stalls, plus one long hold-off counted here.
    int sink_gap;
    int hold_cnt;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
            hold_cnt <= 0;
        end else if (hold_req && hold_cnt < HOLD_CYC) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted input beat, checks every output beat.
    always @(posedge aclk) begin
        grad_beat_t  gb;
        delta_beat_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                gb = s_tdata[IDX_W+DATA_W-1:0];
                delta_queue.push_back(adagrad_delta(gb));
                sent_count <= sent_count + 1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[IDX_W+DATA_W-1:0];
                if (delta_queue.size() == 0) begin
                    report_mismatch("unexpected beat", {20'd0, got.idx}, 32'd0);
                end else begin
                    want = delta_queue.pop_front();
                    if (got.idx !== want.idx)
                        report_mismatch("out_index", {20'd0, got.idx}, {20'd0, want.idx});
                    if (got.delta !== want.delta)
                        report_mismatch("delta", got.delta, want.delta);
                end
            end
        end
    end

    // Watchdog; the clearing pass after reset counts as idle too, so the limit
    // covers it with plenty of margin.
    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT + NW) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'd0;
        pwdata      = 32'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        err_count   = 0;
        sent_count  = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        hold_req    = 1'b0;
        lr_reg      = LR_RESET;
        eps_reg     = EPS_RESET;
        batch_reg   = BATCH_RESET;
        for (int i = 0; i < NW; i++) sq_store[i] = 32'd0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed beats at reset settings: zero gradient, extremes of both fields,
        // repeated hits on one element so the store saturates.
        push_beat(12'd0, 32'd0);
        push_beat(12'd0, 32'h0001_0000);
        push_beat(12'hFFF, 32'h7FFF_FFFF);
        push_beat(12'hFFF, 32'h8000_0000);
        push_beat(12'd5, 32'hFFFF_FFFF);
        push_beat(12'd5, 32'd1);
        for (int i = 0; i < 6; i++) push_beat(12'd7, 32'h8000_0000);
        push_beat(12'hAAA, 32'h5555_5555);
        push_beat(12'h555, 32'hAAAA_AAAA);
        wait_idle();

        // Zero epsilon with zero gradient on a fresh element: zero denominator.
        // Zero batch size counts as one. Maximum rate brings the delta magnitude to 0x7FFF_FFFF.
        set_regs(32'h7FFF_FFFF, 32'd0, 32'd0);
        push_beat(12'd100, 32'd0);
        push_beat(12'd101, 32'd1);
        push_beat(12'd102, 32'hFFFF_FFFF);
        push_beat(12'd103, 32'h0000_0100);
        push_beat(12'd104, 32'hFFFF_FF00);
        wait_idle();
        set_regs(32'd0, 32'h7FFF_FFFF, 32'd65535);
        push_beat(12'd200, 32'h7FFF_FFFF);
        push_beat(12'd201, 32'h8000_0000);
        wait_idle();

        // Random phases under a spread of settings, extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_regs(32'h0001_0000, 32'd1, 32'd1);
                1:       set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535);
                2:       set_regs(32'd0, 32'd0, 32'd1);
                3:       set_regs(32'h7FFF_FFFF, 32'd0, 32'd1);
                default: set_regs($urandom_range(0, 32'h0010_0000),
                                  $urandom_range(0, 32'h0000_1000),
                                  $urandom_range(0, 1) ? $urandom_range(1, 16)
                                                       : $urandom_range(0, 65535));
            endcase
            if (ph == 1) hold_req = 1'b1;  // sink stalls while the source keeps going
            if (ph == 7) quiet_phase = 1'b1;
            for (int i = 0; i < 250; i++)
                push_beat($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 15),
                          rand_grad());
            wait_idle();
        end

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/agwu_pkg.sv
rtl/adagrad_weight_update.sv
sim/tb_adagrad_weight_update.sv
